@@ rtl/wlrts_pkg.sv @@
// ============================================================================
// Wideband lambda scheduler package
// Word layouts, register indexes and the lambda to millivolt conversion.
// ============================================================================
package wlrts_pkg;

    localparam int unsigned IN_DATA_W  = 112;
    localparam int unsigned OUT_DATA_W = 48;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RX_FRAME_ID      = 2'd0,
        CFG_FAST_PERIOD_MS   = 2'd1,
        CFG_SLOW_PERIOD_MS   = 2'd2,
        CFG_STALE_TIMEOUT_MS = 2'd3
    } cfg_index_t;

    localparam logic        KIND_FRAME = 1'b0;
    localparam logic        KIND_TICK  = 1'b1;

    localparam logic [10:0] RX_FRAME_ID_RESET  = 11'h180;
    localparam logic [15:0] FAST_PERIOD_RESET  = 16'd10;
    localparam logic [15:0] SLOW_PERIOD_RESET  = 16'd100;
    localparam logic [15:0] STALE_TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] LAMBDA_RESET       = 16'd1000;
    localparam logic [7:0]  STATUS_RESET       = 8'd0;
    localparam logic [15:0] MV_RESET           = 16'd500;
    localparam logic [3:0]  MIN_FRAME_LENGTH   = 4'd3;

    localparam logic [15:0] LAMBDA_MIN = 16'd700;
    localparam logic [15:0] LAMBDA_MAX = 16'd1300;
    localparam logic [15:0] RECIP_3    = 16'd43691;
    localparam int unsigned RECIP_SHIFT = 17;

    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] analog_o2_mv;
        logic [7:0]  sensor_status_byte;
        logic [7:0]  lambda_high_byte;
        logic [7:0]  lambda_low_byte;
        logic [3:0]  frame_length;
        logic        frame_extended;
        logic [28:0] frame_id;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  pad;
        logic        slow_frame_due;
        logic        fast_frame_due;
        logic [15:0] o2_mv_effective;
        logic        lambda_fresh;
        logic [7:0]  lambda_status;
        logic [15:0] lambda_x1000;
        logic        frame_accepted;
    } out_word_t;

    // Lambda clamped to 700..1300, then (1300 - l) * 1000 / 600. The scale
    // 5/3 uses a reciprocal multiply that is exact for products up to 3000.
    function automatic logic [15:0] o2_mv_from_lambda(input logic [15:0] lambda);
        logic [15:0] clamped;
        logic [9:0]  span;
        logic [11:0] scaled;
        logic [27:0] product;
        clamped = lambda;
        if (lambda < LAMBDA_MIN)
        begin
            clamped = LAMBDA_MIN;
        end
        if (lambda > LAMBDA_MAX)
        begin
            clamped = LAMBDA_MAX;
        end
        span    = 10'(LAMBDA_MAX - clamped);
        scaled  = 12'({span, 2'b00}) + 12'(span);
        product = 28'(scaled) * 28'(RECIP_3);
        return 16'(product >> RECIP_SHIFT);
    endfunction

endpackage

@@ rtl/wideband_lambda_rx_and_tx_scheduler.sv @@
// ============================================================================
// Wideband lambda receive filter and transmit scheduler
// Takes received frames and process ticks, keeps the latest lambda reading
// and reports freshness, effective O2 millivolts and due transmit frames.
// ============================================================================
//  channel  direction  tuser  tdata fields
//  s_*      in         kind   now_ms, frame_id, frame_extended, frame_length,
//                             lambda_low_byte, lambda_high_byte,
//                             sensor_status_byte, analog_o2_mv
//  m_*      out        -      frame_accepted, lambda_x1000, lambda_status,
//                             lambda_fresh, o2_mv_effective, fast_frame_due,
//                             slow_frame_due
//  cfg_*    in         -      register index and 16-bit write data
//
// One word per cycle unless m_tready stalls; each word passes the input
// register and then waits in the result register until it is taken.
// The input register also holds the millivolt conversion of the incoming
// lambda bytes, so the state update and result selection need not compute it.
// A stall on m_tready holds the result register and backs up into s_tready
// only once both are full. Reset initialises all but the word registers.
// ============================================================================
module wideband_lambda_rx_and_tx_scheduler #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms, frame_id, frame_extended, frame_length, lambda_low_byte,
    // lambda_high_byte, sensor_status_byte, analog_o2_mv, zero fill
    input  logic [wlrts_pkg::IN_DATA_W-1:0]    s_tdata,
    // kind
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // frame_accepted, lambda_x1000, lambda_status, lambda_fresh,
    // o2_mv_effective, fast_frame_due, slow_frame_due, zero fill
    output logic [wlrts_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                               cfg_we,
    input  logic [wlrts_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wlrts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [10:0]            rx_frame_id_reg;
    logic [15:0]            fast_period_reg;
    logic [15:0]            slow_period_reg;
    logic [15:0]            stale_timeout_reg;

    logic                   in_valid_reg;
    wlrts_pkg::in_word_t    in_word_reg;
    logic                   in_kind_reg;
    logic [15:0]            in_mv_reg;
    logic                   out_valid_reg;
    wlrts_pkg::out_word_t   out_word_reg;
    wlrts_pkg::out_word_t   out_word_next;

    logic [15:0]            lambda_reg;
    logic [15:0]            lambda_next;
    logic [7:0]             status_reg;
    logic [7:0]             status_next;
    logic [15:0]            mv_reg;
    logic [15:0]            mv_next;
    logic [TIME_WIDTH-1:0]  last_rx_reg;
    logic [TIME_WIDTH-1:0]  last_rx_next;
    logic                   seen_reg;
    logic                   seen_next;

    wlrts_pkg::in_word_t    s_word;
    logic                   in_take;
    logic                   out_free;
    logic                   advance;
    logic                   tick;
    logic                   accepted;
    logic                   fresh;
    logic                   fast_due;
    logic                   slow_due;
    logic [TIME_WIDTH-1:0]  now_time;
    logic [TIME_WIDTH-1:0]  rx_age;

    assign s_word   = wlrts_pkg::in_word_t'(s_tdata);
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;

    assign now_time = TIME_WIDTH'(in_word_reg.now_ms);
    assign tick     = advance && (in_kind_reg == wlrts_pkg::KIND_TICK);
    assign accepted = (in_kind_reg == wlrts_pkg::KIND_FRAME)
                   && !in_word_reg.frame_extended
                   && (in_word_reg.frame_id == 29'(rx_frame_id_reg))
                   && (in_word_reg.frame_length >= wlrts_pkg::MIN_FRAME_LENGTH);
    assign rx_age   = now_time - last_rx_reg;
    assign fresh    = accepted
                   || (seen_reg && (rx_age <= TIME_WIDTH'(stale_timeout_reg)));

    wlrts_period_timer #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fast_timer (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .now_time (now_time),
        .period   (fast_period_reg),
        .due      (fast_due)
    );

    wlrts_period_timer #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_slow_timer (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .now_time (now_time),
        .period   (slow_period_reg),
        .due      (slow_due)
    );

    always_comb
    begin
        lambda_next  = lambda_reg;
        status_next  = status_reg;
        mv_next      = mv_reg;
        last_rx_next = last_rx_reg;
        seen_next    = seen_reg;
        if (advance && accepted)
        begin
            lambda_next  = {in_word_reg.lambda_high_byte, in_word_reg.lambda_low_byte};
            status_next  = in_word_reg.sensor_status_byte;
            mv_next      = in_mv_reg;
            last_rx_next = now_time;
            seen_next    = 1'b1;
        end
    end

    always_comb
    begin
        out_word_next                 = '0;
        out_word_next.frame_accepted  = accepted;
        out_word_next.lambda_x1000    = lambda_next;
        out_word_next.lambda_status   = status_next;
        out_word_next.lambda_fresh    = fresh;
        out_word_next.o2_mv_effective = fresh ? mv_next : in_word_reg.analog_o2_mv;
        out_word_next.fast_frame_due  = (in_kind_reg == wlrts_pkg::KIND_TICK) && fast_due;
        out_word_next.slow_frame_due  = (in_kind_reg == wlrts_pkg::KIND_TICK) && slow_due;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_frame_id_reg   <= wlrts_pkg::RX_FRAME_ID_RESET;
            fast_period_reg   <= wlrts_pkg::FAST_PERIOD_RESET;
            slow_period_reg   <= wlrts_pkg::SLOW_PERIOD_RESET;
            stale_timeout_reg <= wlrts_pkg::STALE_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (wlrts_pkg::cfg_index_t'(cfg_index))
                wlrts_pkg::CFG_RX_FRAME_ID:      rx_frame_id_reg   <= cfg_wdata[10:0];
                wlrts_pkg::CFG_FAST_PERIOD_MS:   fast_period_reg   <= cfg_wdata;
                wlrts_pkg::CFG_SLOW_PERIOD_MS:   slow_period_reg   <= cfg_wdata;
                wlrts_pkg::CFG_STALE_TIMEOUT_MS: stale_timeout_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lambda_reg    <= wlrts_pkg::LAMBDA_RESET;
            status_reg    <= wlrts_pkg::STATUS_RESET;
            mv_reg        <= wlrts_pkg::MV_RESET;
            last_rx_reg   <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            lambda_reg  <= lambda_next;
            status_reg  <= status_next;
            mv_reg      <= mv_next;
            last_rx_reg <= last_rx_next;
            seen_reg    <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= s_word;
            in_kind_reg <= s_tuser;
            in_mv_reg   <= wlrts_pkg::o2_mv_from_lambda({s_word.lambda_high_byte,
                                                         s_word.lambda_low_byte});
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    a_accept_not_due: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.frame_accepted
        |-> !out_word_reg.fast_frame_due && !out_word_reg.slow_frame_due)
        else $error("accepted frame reported a due transmit frame");

    a_accept_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.frame_accepted |-> out_word_reg.lambda_fresh)
        else $error("accepted frame not reported fresh");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with room in the pipeline");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word did not reach the result register");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |=> seen_reg)
        else $error("reading seen flag cleared outside reset");

endmodule

@@ rtl/wlrts_period_timer.sv @@
// ============================================================================
// Wrap-safe period timer
// Raises due once the period has elapsed since the last firing; a tick
// while due counts as a firing and restarts the timer from the tick time.
// ============================================================================
module wlrts_period_timer #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tick,
    input  logic [TIME_WIDTH-1:0] now_time,
    input  logic [15:0]           period,
    output logic                  due
);

    logic [TIME_WIDTH-1:0] last_time_reg;
    logic [TIME_WIDTH-1:0] last_time_next;
    logic [TIME_WIDTH-1:0] elapsed;

    assign elapsed = now_time - last_time_reg;
    assign due     = elapsed >= TIME_WIDTH'(period);

    always_comb
    begin
        last_time_next = last_time_reg;
        if (tick && due)
        begin
            last_time_next = now_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else
        begin
            last_time_reg <= last_time_next;
        end
    end

endmodule
